// File: rtl/mase_pkg.sv
// shared types and constants for the multi-axis step generator
// no dependencies; imported by every module of the block
package mase_pkg;

   localparam int AXES        = 3;
   localparam int FIELD_AXES  = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int REQ_DATA_W  = 248;
   localparam int RSP_DATA_W  = 32;
   localparam int DIR_HEAD    = 3;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_RAMP  = 3'd1;
   localparam logic [2:0] OP_CONST = 3'd2;
   localparam logic [2:0] OP_HEAD  = 3'd3;
   localparam logic [2:0] OP_HOME  = 3'd4;

   localparam logic [2:0] ST_RUNNING  = 3'd0;
   localparam logic [2:0] ST_NEXT     = 3'd1;
   localparam logic [2:0] ST_ACCEPTED = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_ABORTED  = 3'd4;
   localparam logic [2:0] ST_HOMED    = 3'd5;

   localparam logic [1:0] QC_LOAD_DIR  = 2'd0;
   localparam logic [1:0] QC_HARD_STOP = 2'd3;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [2:0]                op;
      logic                      set_stop;
      logic                      load_dir;
      logic                      head_dir;
      logic [15:0]               duty;
      logic [2:0]                sensors;
      logic                      shutdown;
      logic [1:0]                home_axis;
      logic                      home_none;
      word_type [AXES-1:0]       steps;
      word_type [AXES-1:0]       rate;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  pulses;
      logic [3:0]  dir_load;
      logic [3:0]  dir_bits;
      logic        duty_load;
      logic [15:0] duty_value;
      logic        homing_busy;
   } rsp_type;

endpackage

// File: rtl/mase_front.sv
// front end: accepts request items, unpacks and classifies them into commands
// depends on mase_pkg
module mase_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mase_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [2:0]                         req_tuser,
   input  logic                               q_full,
   output logic                               q_push,
   output mase_pkg::cmd_type                  q_cmd
);
   import mase_pkg::*;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_cmd           = '0;
      q_cmd.op        = req_tuser;
      q_cmd.set_stop  = (req_tdata[1:0] == QC_HARD_STOP);
      q_cmd.load_dir  = (req_tdata[1:0] == QC_LOAD_DIR);
      q_cmd.head_dir  = !req_tdata[225];
      q_cmd.duty      = req_tdata[241:226];
      q_cmd.sensors   = req_tdata[244:242];
      q_cmd.shutdown  = req_tdata[245];
      q_cmd.home_none = 1'b1;
      q_cmd.home_axis = '0;
      for (int i = 0; i < AXES; i++) begin
         if (i < FIELD_AXES) begin
            q_cmd.steps[i] = req_tdata[2 + 32*i +: 32];
            q_cmd.rate[i]  = req_tdata[98 + 32*i +: 32];
         end
      end
      // first axis with a nonzero step count is the one to home
      for (int i = FIELD_AXES - 1; i >= 0; i--) begin
         if (i < AXES && req_tdata[2 + 32*i +: 32] != '0) begin
            q_cmd.home_axis = 2'(i);
            q_cmd.home_none = 1'b0;
         end
      end
   end

endmodule

// File: rtl/mase_queue.sv
// short command queue between the front and back ends
// depends on mase_pkg
module mase_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mase_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output mase_pkg::cmd_type  pop_cmd
);
   import mase_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/mase_back.sv
// back end: axis state, command execution and the result register
// depends on mase_pkg
module mase_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  mase_pkg::cmd_type  q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mase_pkg::rsp_type  rsp
);
   import mase_pkg::*;

   word_type   budget_ff [AXES];
   word_type   budget_in [AXES];
   word_type   speed_ff  [AXES];
   word_type   speed_in  [AXES];
   word_type   accel_ff  [AXES];
   word_type   accel_in  [AXES];
   word_type   phase_ff  [AXES];
   word_type   phase_in  [AXES];
   word_type   spd_sum   [AXES];
   word_type   ph_sum    [AXES];
   logic       stop_ff, stop_in;
   logic       homing_ff, homing_in;
   logic [1:0] haxis_ff, haxis_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       all_done;
   logic       run;
   logic       do_poll;
   logic [1:0] poll_axis;
   logic       sensed;

   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      budget_in    = budget_ff;
      speed_in     = speed_ff;
      accel_in     = accel_ff;
      phase_in     = phase_ff;
      stop_in      = stop_ff;
      homing_in    = homing_ff;
      haxis_in     = haxis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      all_done     = 1'b1;
      run          = 1'b0;
      do_poll      = 1'b0;
      poll_axis    = haxis_ff;
      sensed       = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         spd_sum[i] = speed_ff[i] + accel_ff[i];
         ph_sum[i]  = phase_ff[i] + spd_sum[i];
      end

      if (q_pop) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (homing_ff) begin
            do_poll = 1'b1;
         end else begin
            if (q_cmd.op != OP_TICK) begin
               stop_in = q_cmd.set_stop;
            end
            unique case (q_cmd.op)
               OP_TICK: begin
                  for (int i = 0; i < AXES; i++) begin
                     run = 1'b1;
                     if (budget_ff[i] != '0 && !budget_ff[i][31]) begin
                        all_done = 1'b0;
                     end else if (stop_ff) begin
                        run = 1'b0;
                     end
                     if (run) begin
                        speed_in[i] = spd_sum[i];
                        phase_in[i] = ph_sum[i];
                        // signed overflow of the phase add gives a step
                        if (((phase_ff[i] ^ ph_sum[i]) & (spd_sum[i] ^ ph_sum[i])) >> 31
                            != '0) begin
                           budget_in[i] = budget_ff[i] - 32'd1;
                           if (i < FIELD_AXES) begin
                              rsp_in.pulses[i] = 1'b1;
                           end
                        end
                     end
                  end
                  rsp_in.status = all_done ? ST_NEXT : ST_RUNNING;
               end
               OP_RAMP: begin
                  for (int i = 0; i < AXES; i++) begin
                     if (q_cmd.load_dir && i < FIELD_AXES) begin
                        rsp_in.dir_load[i] = 1'b1;
                        rsp_in.dir_bits[i] = !q_cmd.rate[i][31];
                     end
                     budget_in[i] = budget_ff[i] + q_cmd.steps[i];
                     accel_in[i]  = q_cmd.rate[i];
                  end
                  rsp_in.status = ST_ACCEPTED;
               end
               OP_CONST, OP_HOME: begin
                  for (int i = 0; i < AXES; i++) begin
                     budget_in[i] = budget_ff[i] + q_cmd.steps[i];
                     accel_in[i]  = '0;
                     speed_in[i]  = q_cmd.rate[i];
                  end
                  if (q_cmd.op == OP_CONST) begin
                     rsp_in.status = ST_ACCEPTED;
                  end else if (q_cmd.home_none) begin
                     rsp_in.status = ST_HOMED;
                  end else begin
                     haxis_in  = q_cmd.home_axis;
                     poll_axis = q_cmd.home_axis;
                     do_poll   = 1'b1;
                  end
               end
               OP_HEAD: begin
                  rsp_in.dir_load[DIR_HEAD] = 1'b1;
                  rsp_in.dir_bits[DIR_HEAD] = q_cmd.head_dir;
                  rsp_in.duty_load          = 1'b1;
                  rsp_in.duty_value         = q_cmd.duty;
                  rsp_in.status             = ST_ACCEPTED;
               end
               default: begin
                  rsp_in.status = ST_REJECTED;
               end
            endcase
         end

         // sensor first, then shutdown
         if (do_poll) begin
            for (int i = 0; i < FIELD_AXES; i++) begin
               if (i < AXES && poll_axis == 2'(i) && q_cmd.sensors[i]) begin
                  sensed = 1'b1;
               end
            end
            if (sensed) begin
               for (int i = 0; i < AXES; i++) begin
                  if (poll_axis == 2'(i)) begin
                     budget_in[i] = '0;
                  end
               end
               homing_in     = 1'b0;
               rsp_in.status = ST_HOMED;
            end else if (q_cmd.shutdown) begin
               homing_in     = 1'b0;
               rsp_in.status = ST_ABORTED;
            end else begin
               homing_in     = 1'b1;
               rsp_in.status = ST_RUNNING;
            end
         end
         rsp_in.homing_busy = homing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            budget_ff[i] <= '0;
            speed_ff[i]  <= '0;
            accel_ff[i]  <= '0;
            phase_ff[i]  <= '0;
         end
         stop_ff      <= 1'b0;
         homing_ff    <= 1'b0;
         haxis_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         budget_ff    <= budget_in;
         speed_ff     <= speed_in;
         accel_ff     <= accel_in;
         phase_ff     <= phase_in;
         stop_ff      <= stop_in;
         homing_ff    <= homing_in;
         haxis_ff     <= haxis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff)
      else $error("popped item produced no result");

   a_tick_no_homing: assert property (@(posedge clock) disable iff (reset)
      q_pop && !homing_ff && q_cmd.op == OP_TICK |=> !homing_ff)
      else $error("tick started a homing wait");

   a_busy_matches: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_ff.homing_busy == homing_ff)
      else $error("homing busy flag disagrees with homing state");

   a_idle_holds_homing: assert property (@(posedge clock) disable iff (reset)
      !q_pop |=> $stable(homing_ff) && $stable(haxis_ff))
      else $error("homing state changed without an item");

endmodule

// File: rtl/multi_axis_step_generator_core.sv
// top level of the three-axis stepper step generator
// depends on mase_pkg, mase_front, mase_queue and mase_back
//
// Takes one tick or command item per clock and returns one result item for each, in order.
// The front end decodes each item into a two-entry command queue; the back end executes one
// command per cycle against the per-axis budget, speed, acceleration and phase registers and
// places the result in an output register. An accepted item is first written into the queue, and
// its result is then registered for rsp_tvalid; while rsp_tready stays high one item is taken every cycle.
// When the result side stalls, the queue still absorbs up to two more items before
// req_tready drops.
// During a homing wait every item is only a poll of the home sensor and shutdown request.
module multi_axis_step_generator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // queue_count, steps_axis0..2, rate_axis0..2, head_direction, head_duty,
   // home_sensors, shutdown_request, zero pad
   input  logic [mase_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op
   input  logic [2:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // step_pulses, direction_load, direction_bits, duty_load, duty_value,
   // homing_busy, zero pad
   output logic [mase_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [2:0]                         rsp_tuser
);
   import mase_pkg::*;

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_valid;
   cmd_type push_cmd;
   cmd_type pop_cmd;
   rsp_type rsp;

   mase_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   mase_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   mase_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {3'b000, rsp.homing_busy, rsp.duty_value, rsp.duty_load,
                       rsp.dir_bits, rsp.dir_load, rsp.pulses};

endmodule
